// ===== src/mswd_pkg.sv =====
`default_nettype none
package mswd_pkg;

	localparam logic [1:0] ACT_REGISTER   = 2'd0;
	localparam logic [1:0] ACT_UNREGISTER = 2'd1;
	localparam logic [1:0] ACT_ALIVE      = 2'd2;
	localparam logic [1:0] ACT_CHECK      = 2'd3;

	localparam logic [1:0] KIND_DONE     = 2'd0;
	localparam logic [1:0] KIND_ERROR    = 2'd1;
	localparam logic [1:0] KIND_EXCEEDED = 2'd2;
	localparam logic [1:0] KIND_CHECKED  = 2'd3;

	localparam logic CFG_CHECK_PERIOD = 1'b0;
	localparam logic CFG_REPORTING    = 1'b1;

	localparam logic [15:0] RESET_CHECK_PERIOD = 16'd100;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot_out;
		logic [31:0] limit_out;
		logic [15:0] tag_out;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// ===== src/mswd_out_reg.sv =====
`default_nettype none
module mswd_out_reg
	import mswd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire result_t     load_data,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // slot_out, limit_out, tag_out, zero fill
	output logic [1:0]       m_tuser,  // kind
	output logic             m_tlast
);

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = data_q.kind;
	assign m_tlast  = data_q.last;
	assign m_tdata  = {4'd0, data_q.tag_out, data_q.limit_out, data_q.slot_out};

endmodule
`default_nettype wire

// ===== src/multi_slot_watchdog_table.sv =====
// Channel   Direction  Handshake            Content
// s_*       in         s_tvalid / s_tready  tuser action; tdata slot, interval, tag, debugger
// m_*       out        m_tvalid / m_tready  tuser kind; tdata slot, limit, tag; tlast last
// cfg_*     in         cfg_we               cfg_index register, cfg_data value
//
// Register, unregister and alive are accepted in ST_IDLE and update the table in ST_EXEC.
// A check reads the slot memory once per slot, unless reporting is off, then ends in ST_FIN.
// Each reported slot and the final result wait while the output register is full.
// Reset clears the valid and fired flags, the block time, the state and the config registers; the slot
// memories are not cleared.
`default_nettype none
module multi_slot_watchdog_table
	import mswd_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // slot, max_interval_ms, caller_tag, debugger_present
	input  wire logic [1:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // slot_out, limit_out, tag_out, zero fill
	output logic [1:0]       m_tuser,  // kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_CHK  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]           state_q;
	logic [15:0]          period_q;
	logic                 report_q;
	logic [31:0]          time_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NUM_SLOTS-1:0] fired_q;

	logic [1:0]  action_q;
	logic [3:0]  slot_q;
	logic [31:0] limit_q;
	logic [15:0] tag_q;
	logic        dbg_q;

	logic [CW-1:0] rd_idx_q;
	logic          ev_valid_s1;
	logic [SW-1:0] ev_idx_s1;

	logic [47:0] st_mem [NUM_SLOTS];
	logic [31:0] lim_mem [NUM_SLOTS];
	logic [47:0] st_rd_s1;
	logic [31:0] lim_rd_s1;

	logic          accept;
	logic          out_free;
	logic          out_load;
	result_t       out_data;
	logic          rd_done;
	logic          rd_en;
	logic          adv;
	logic          fire;
	logic          ev_live;
	logic [31:0]   stamp_eff;
	logic          st_we;
	logic [SW-1:0] st_waddr;
	logic [47:0]   st_wdata;
	logic          lim_we;
	logic [SW-1:0] idx;
	logic          in_rng;
	logic          cur_valid;
	logic          op_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign idx       = SW'(slot_q);
	assign in_rng    = 32'(slot_q) < NUM_SLOTS;
	assign cur_valid = in_rng ? valid_q[idx] : 1'b0;

	always_comb begin
		case (action_q)
			ACT_REGISTER: op_ok = in_rng && !cur_valid;
			default:      op_ok = cur_valid;
		endcase
	end

	assign rd_done   = (rd_idx_q == CW'(NUM_SLOTS));
	assign ev_live   = ev_valid_s1 && valid_q[ev_idx_s1];
	assign stamp_eff = dbg_q ? time_q : st_rd_s1[47:16];
	assign fire      = ev_live && !fired_q[ev_idx_s1] &&
			((time_q - stamp_eff) > lim_rd_s1);
	assign adv       = (state_q == ST_CHK) && !(fire && !out_free);
	assign rd_en     = adv && !rd_done;

	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		out_data.slot_out = slot_q;
		out_data.last     = 1'b1;
		out_data.kind     = op_ok ? KIND_DONE : KIND_ERROR;
		case (state_q)
			ST_EXEC: begin
				out_load = 1'b1;
			end
			ST_CHK: begin
				out_load           = fire;
				out_data.kind      = KIND_EXCEEDED;
				out_data.slot_out  = 4'(ev_idx_s1);
				out_data.limit_out = lim_rd_s1;
				out_data.tag_out   = st_rd_s1[15:0];
				out_data.last      = 1'b0;
			end
			ST_FIN: begin
				out_load          = 1'b1;
				out_data.kind     = KIND_CHECKED;
				out_data.slot_out = '0;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		st_we    = 1'b0;
		st_waddr = idx;
		st_wdata = {time_q, tag_q};
		lim_we   = 1'b0;
		if (state_q == ST_EXEC && out_free && op_ok) begin
			st_we  = (action_q == ACT_REGISTER) || (action_q == ACT_ALIVE);
			lim_we = (action_q == ACT_REGISTER);
		end else if (adv && ev_live && dbg_q) begin
			st_we    = 1'b1;
			st_waddr = ev_idx_s1;
			st_wdata = {time_q, st_rd_s1[15:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (lim_we) begin
			lim_mem[idx] <= limit_q;
		end
		if (rd_en) begin
			st_rd_s1  <= st_mem[rd_idx_q[SW-1:0]];
			lim_rd_s1 <= lim_mem[rd_idx_q[SW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= s_tuser;
			slot_q   <= s_tdata[3:0];
			limit_q  <= s_tdata[35:4];
			tag_q    <= s_tdata[51:36];
			dbg_q    <= s_tdata[52];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_CHECK_PERIOD;
			report_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHECK_PERIOD: period_q <= cfg_data;
				CFG_REPORTING:    report_q <= cfg_data[0];
				default:          report_q <= report_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			valid_q     <= '0;
			fired_q     <= '0;
			rd_idx_q    <= '0;
			ev_valid_s1 <= 1'b0;
			ev_idx_s1   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_idx_q    <= '0;
					ev_valid_s1 <= 1'b0;
					if (accept) begin
						if (s_tuser == ACT_CHECK) begin
							time_q  <= time_q + 32'(period_q);
							state_q <= report_q ? ST_CHK : ST_FIN;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (op_ok) begin
							case (action_q)
								ACT_REGISTER: begin
									valid_q[idx] <= 1'b1;
									fired_q[idx] <= 1'b0;
								end
								ACT_UNREGISTER: valid_q[idx] <= 1'b0;
								default:        valid_q[idx] <= 1'b1;
							endcase
						end
					end
				end
				ST_CHK: begin
					if (adv) begin
						if (fire) begin
							fired_q[ev_idx_s1] <= 1'b1;
						end
						ev_valid_s1 <= !rd_done;
						ev_idx_s1   <= rd_idx_q[SW-1:0];
						if (rd_done) begin
							state_q <= ST_FIN;
						end else begin
							rd_idx_q <= rd_idx_q + CW'(1);
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mswd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.load_data(out_data),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= CW'(NUM_SLOTS))
		else $error("slot walk ran past the table");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("check did not end with a final transfer");

	a_fire_once: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fire) |=> fired_q[$past(ev_idx_s1)])
		else $error("reported slot not marked as fired");

	a_no_report_off: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ACT_CHECK && !report_q) |=> (state_q == ST_FIN))
		else $error("slots walked with reporting disabled");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mswd_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [31:0] interval;
		logic [15:0] tag;
		logic        dbg;
	} watch_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	multi_slot_watchdog_table #(.NUM_SLOTS(NUM_SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the watch table.
	logic        wd_valid [NUM_SLOTS];
	logic [31:0] wd_limit [NUM_SLOTS];
	logic [31:0] wd_stamp [NUM_SLOTS];
	logic        wd_fired [NUM_SLOTS];
	logic [15:0] wd_tag [NUM_SLOTS];
	logic [31:0] wd_time = '0;
	logic [15:0] wd_period = RESET_CHECK_PERIOD;
	logic        wd_report = 1'b1;

	watch_req_t  req_feed [$];
	result_t     due_reports [$];
	watch_req_t  next_req;
	watch_req_t  seen_req;
	result_t     got;
	result_t     want;
	bit          item_taken = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int unsigned send_idle = 36;
	int unsigned recv_idle = 51;
	int          idle_cycles = 0;
	int          errors = 0;
	int          items_in = 0;
	int          results_out = 0;
	int          timeouts_seen = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic push_report(input logic [1:0] kind, input logic [3:0] slot,
			input logic [31:0] limit, input logic [15:0] tag, input logic last);
		result_t res;
		res.kind = kind;
		res.slot_out = slot;
		res.limit_out = limit;
		res.tag_out = tag;
		res.last = last;
		due_reports.push_back(res);
	endtask

	task automatic predict_watch(input watch_req_t r);
		logic [31:0] elapsed;
		logic [1:0]  kind;
		if (r.action == ACT_CHECK) begin
			wd_time = wd_time + {16'd0, wd_period};
			if (wd_report) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (wd_valid[i]) begin
						if (r.dbg) begin
							wd_stamp[i] = wd_time;
						end
						elapsed = wd_time - wd_stamp[i];
						if (!wd_fired[i] && elapsed > wd_limit[i]) begin
							push_report(KIND_EXCEEDED, 4'(i), wd_limit[i], wd_tag[i], 1'b0);
							wd_fired[i] = 1'b1;
						end
					end
				end
			end
			push_report(KIND_CHECKED, 4'd0, 32'd0, 16'd0, 1'b1);
		end else begin
			kind = KIND_DONE;
			case (r.action)
				ACT_REGISTER: begin
					if (wd_valid[r.slot]) begin
						kind = KIND_ERROR;
					end else begin
						wd_valid[r.slot] = 1'b1;
						wd_limit[r.slot] = r.interval;
						wd_stamp[r.slot] = wd_time;
						wd_tag[r.slot] = r.tag;
						wd_fired[r.slot] = 1'b0;
					end
				end
				ACT_UNREGISTER: begin
					if (!wd_valid[r.slot]) begin
						kind = KIND_ERROR;
					end else begin
						wd_valid[r.slot] = 1'b0;
					end
				end
				default: begin
					if (!wd_valid[r.slot]) begin
						kind = KIND_ERROR;
					end else begin
						wd_stamp[r.slot] = wd_time;
						wd_tag[r.slot] = r.tag;
					end
				end
			endcase
			push_report(kind, r.slot, 32'd0, 16'd0, 1'b1);
		end
	endtask

	task automatic push_req(input logic [1:0] action, input logic [3:0] slot,
			input logic [31:0] interval, input logic [15:0] tag, input logic dbg);
		watch_req_t r;
		r.action = action;
		r.slot = slot;
		r.interval = interval;
		r.tag = tag;
		r.dbg = dbg;
		req_feed.push_back(r);
	endtask

	// Mostly well-formed table traffic, with limits scaled to the check period
	// so that slots actually time out, plus a little fully random noise.
	function automatic watch_req_t roll_req(input int unsigned period);
		watch_req_t  r;
		int unsigned pick;
		r.slot = 4'($urandom_range(NUM_SLOTS - 1));
		r.interval = $urandom;
		r.tag = 16'($urandom);
		r.dbg = 1'b0;
		pick = $urandom_range(99);
		if (pick < 30) begin
			r.action = ACT_CHECK;
			r.dbg = ($urandom_range(9) == 0);
		end else if (pick < 55) begin
			r.action = ACT_REGISTER;
			case ($urandom_range(9))
				0: r.interval = $urandom;
				1: r.interval = 32'd0;
				default: r.interval = $urandom_range(5 * period + 1);
			endcase
		end else if (pick < 70) begin
			r.action = ACT_UNREGISTER;
		end else if (pick < 95) begin
			r.action = ACT_ALIVE;
		end else begin
			r.action = 2'($urandom);
			r.dbg = 1'($urandom);
		end
		return r;
	endfunction

	task automatic queue_random(input int n, input int unsigned period);
		for (int k = 0; k < n; k++) begin
			req_feed.push_back(roll_req(period));
		end
	endtask

	task automatic settle();
		while (req_feed.size() != 0 || s_tvalid || due_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (NUM_SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHECK_PERIOD) begin
			wd_period = val;
		end else begin
			wd_report = val[0];
		end
	endtask

	// Sender: holds an offered item until its transfer, then may pause.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || item_taken) begin
			item_taken = 1'b0;
			if (req_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_req = req_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_req.action;
				s_tdata <= {3'b000, next_req.dbg, next_req.tag, next_req.interval,
					next_req.slot};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or one long hold-off when requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			seen_req.action = s_tuser;
			seen_req.slot = s_tdata[3:0];
			seen_req.interval = s_tdata[35:4];
			seen_req.tag = s_tdata[51:36];
			seen_req.dbg = s_tdata[52];
			predict_watch(seen_req);
			item_taken = 1'b1;
			items_in++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.slot_out = m_tdata[3:0];
			got.limit_out = m_tdata[35:4];
			got.tag_out = m_tdata[51:36];
			got.last = m_tlast;
			results_out++;
			if (due_reports.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result with none pending: kind %0d slot %0d limit %h tag %h last %b",
						$realtime, got.kind, got.slot_out, got.limit_out, got.tag_out, got.last);
				end
			end else begin
				want = due_reports.pop_front();
				if (want.kind == KIND_EXCEEDED) begin
					timeouts_seen++;
				end
				if (got.kind !== want.kind || got.slot_out !== want.slot_out ||
						got.limit_out !== want.limit_out || got.tag_out !== want.tag_out ||
						got.last !== want.last) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: expected kind %0d slot %0d limit %h tag %h last %b",
							$realtime, want.kind, want.slot_out, want.limit_out,
							want.tag_out, want.last);
						$display("%0t:      got kind %0d slot %0d limit %h tag %h last %b",
							$realtime, got.kind, got.slot_out, got.limit_out,
							got.tag_out, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			wd_valid[i] = 1'b0;
			wd_fired[i] = 1'b0;
			wd_limit[i] = '0;
			wd_stamp[i] = '0;
			wd_tag[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b0);
		push_req(ACT_REGISTER, 4'd0, 32'd0, 16'hFFFF, 1'b0);
		push_req(ACT_REGISTER, 4'd15, 32'hFFFF_FFFF, 16'h0000, 1'b1);
		push_req(ACT_REGISTER, 4'd0, 32'd7, 16'h1111, 1'b0);
		push_req(ACT_UNREGISTER, 4'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		push_req(ACT_ALIVE, 4'd9, 32'd0, 16'h2222, 1'b1);
		push_req(ACT_REGISTER, 4'd5, 32'd150, 16'hA5A5, 1'b0);
		push_req(ACT_CHECK, 4'd3, 32'd0, 16'd0, 1'b0);
		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b0);
		push_req(ACT_ALIVE, 4'd0, 32'd0, 16'h1234, 1'b0);
		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b1);
		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b0);
		push_req(ACT_UNREGISTER, 4'd0, 32'd0, 16'd0, 1'b0);
		push_req(ACT_REGISTER, 4'd0, 32'd50, 16'h5A5A, 1'b0);
		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b1);
		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b0);
		push_req(ACT_ALIVE, 4'd5, 32'd0, 16'h0F0F, 1'b0);
		push_req(ACT_UNREGISTER, 4'd5, 32'd0, 16'd0, 1'b0);
		push_req(ACT_UNREGISTER, 4'd15, 32'd0, 16'd0, 1'b0);
		push_req(ACT_CHECK, 4'd0, 32'd0, 16'd0, 1'b0);
		settle();

		write_reg(CFG_CHECK_PERIOD, 16'd1);
		queue_random(120, 1);
		settle();

		send_idle = 51;
		recv_idle = 36;
		write_reg(CFG_CHECK_PERIOD, 16'hFFFF);
		write_reg(CFG_REPORTING, 16'd0);
		queue_random(40, 65535);
		settle();
		write_reg(CFG_REPORTING, 16'd1);
		queue_random(80, 65535);
		settle();
		write_reg(CFG_CHECK_PERIOD, 16'd0);
		queue_random(40, 0);
		settle();

		// No idling; the receiver stops for a long stretch so the block backs up.
		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_CHECK_PERIOD, 16'($urandom_range(500, 2)));
		queue_random(110, wd_period);
		hold_req = 1'b1;
		settle();

		$display("Covered %0d watch items and %0d results, %0d slot timeouts,", items_in,
			results_out, timeouts_seen);
		$display("check periods 0, 1, 65535 and random, reporting on and off, with stalls.");
		if (errors == 0 && due_reports.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
